>>> hw/rtl/port_direction_traffic_counter_assert.svh
// Assertion shorthands shared by the RTL.
// Each expects signals named clk and rst_n in the scope where it is used.
`ifndef PORT_DIRECTION_TRAFFIC_COUNTER_ASSERT_SVH
`define PORT_DIRECTION_TRAFFIC_COUNTER_ASSERT_SVH

// same-cycle implication
`define PTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptc assertion failed");

// next-cycle implication
`define PTC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptc assertion failed");

`endif

>>> hw/rtl/ptc_pkg.sv
package ptc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int BYTE_WIDTH  = 48;

  localparam int PORT_W  = 16;
  localparam int LEN_W   = 16;
  localparam int TIME_W  = 32;
  localparam int PCNT_W  = 32;
  localparam int SIZE_W  = 45;
  localparam int IVAL_W  = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_CNT_W = $clog2(BYTE_WIDTH + 1);

  localparam logic [PORT_W-1:0] MON_PORT_RST = 16'd1521;
  localparam logic [IVAL_W-1:0] INTERVAL_RST = 16'd30;

  localparam logic [CFG_IDX_W-1:0] REG_MON_PORT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'b1;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic DIR_TX = 1'b0;
  localparam logic DIR_RX = 1'b1;

  typedef struct packed {
    logic count;        // packet item accepted
    logic snap;         // tick accepted: capture and clear counters
    logic div_load_rx;  // start divide on RX byte snapshot
    logic div_step;     // one quotient bit
    logic out_load;     // load result register
    logic out_rx;       // result being loaded is the RX report
  } ptc_cmd_t;

  typedef struct packed {
    logic div_done;
  } ptc_stat_t;

  typedef struct packed {
    logic              direction;
    logic [TIME_W-1:0] report_time;
    logic [PCNT_W-1:0] packet_count;
    logic [SIZE_W-1:0] size_eighths;
    logic [SIZE_W-1:0] rate_value;
    logic              last;
  } ptc_out_t;

  // value >> 3, fitted to the result field
  function automatic logic [SIZE_W-1:0] eighths(input logic [BYTE_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v >> 3);
    return w[SIZE_W-1:0];
  endfunction

  function automatic logic [PCNT_W-1:0] fit_count(input logic [COUNT_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[PCNT_W-1:0];
  endfunction

endpackage

>>> hw/rtl/ptc_in_if.sv
interface ptc_in_if
  import ptc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [PORT_W-1:0] source_port;
  logic [PORT_W-1:0] destination_port;
  logic [LEN_W-1:0]  packet_length;
  logic [TIME_W-1:0] tick_time;

  modport source (output valid, operation, source_port, destination_port,
                  packet_length, tick_time, input ready);
  modport sink (input valid, operation, source_port, destination_port,
                packet_length, tick_time, output ready);
endinterface

>>> hw/rtl/ptc_out_if.sv
interface ptc_out_if
  import ptc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              direction;
  logic [TIME_W-1:0] report_time;
  logic [PCNT_W-1:0] packet_count;
  logic [SIZE_W-1:0] size_eighths;
  logic [SIZE_W-1:0] rate_value;
  logic              last;

  modport source (output valid, direction, report_time, packet_count,
                  size_eighths, rate_value, last, input ready);
  modport sink (input valid, direction, report_time, packet_count,
                size_eighths, rate_value, last, output ready);
endinterface

>>> hw/rtl/ptc_ctrl.sv
`include "port_direction_traffic_counter_assert.svh"

module ptc_ctrl
  import ptc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_op,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ptc_stat_t stat,
  output ptc_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DIV_TX  = 3'd1;
  localparam logic [2:0] ST_WAIT_TX = 3'd2;
  localparam logic [2:0] ST_DIV_RX  = 3'd3;
  localparam logic [2:0] ST_WAIT_RX = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       accept;
  logic       dividing;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_WAIT_TX) || (state_r == ST_WAIT_RX);
  assign accept    = in_valid && in_ready;
  assign dividing  = (state_r == ST_DIV_TX) || (state_r == ST_DIV_RX);

  always_comb begin
    cmd.count       = accept && (in_op == OP_PACKET);
    cmd.snap        = accept && (in_op == OP_TICK);
    cmd.div_load_rx = (state_r == ST_WAIT_TX) && out_ready;
    cmd.div_step    = dividing && !stat.div_done;
    cmd.out_load    = dividing && stat.div_done;
    cmd.out_rx      = (state_r == ST_DIV_RX);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_op == OP_TICK)) state_nxt = ST_DIV_TX;
      end
      ST_DIV_TX: begin
        if (stat.div_done) state_nxt = ST_WAIT_TX;
      end
      ST_WAIT_TX: begin
        if (out_ready) state_nxt = ST_DIV_RX;
      end
      ST_DIV_RX: begin
        if (stat.div_done) state_nxt = ST_WAIT_RX;
      end
      ST_WAIT_RX: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `PTC_ASSERT_IMP(a_no_input_while_reporting, out_valid, !in_ready)
  `PTC_ASSERT_NXT(a_tx_taken_starts_rx, cmd.div_load_rx, state_r == ST_DIV_RX)
  `PTC_ASSERT_NXT(a_result_after_divide, cmd.out_load, out_valid)
  `PTC_ASSERT_NXT(a_tick_starts_divide, cmd.snap, state_r == ST_DIV_TX)

endmodule

>>> hw/rtl/ptc_datapath.sv
module ptc_datapath
  import ptc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptc_cmd_t             cmd,
  output ptc_stat_t            stat,
  input  logic [PORT_W-1:0]    monitored_port,
  input  logic [IVAL_W-1:0]    interval_seconds,
  input  logic [PORT_W-1:0]    source_port,
  input  logic [PORT_W-1:0]    destination_port,
  input  logic [LEN_W-1:0]     packet_length,
  input  logic [TIME_W-1:0]    tick_time,
  output ptc_out_t             out_item
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [BYTE_WIDTH-1:0]  BYTE_MAX  = '1;

  // live counters
  logic                   last_dir_r, last_dir_nxt;
  logic [COUNT_WIDTH-1:0] tx_pkts_r, tx_pkts_nxt, rx_pkts_r, rx_pkts_nxt;
  logic [BYTE_WIDTH-1:0]  tx_bytes_r, tx_bytes_nxt, rx_bytes_r, rx_bytes_nxt;

  // snapshot taken at the tick
  logic [TIME_W-1:0]      time_r;
  logic [COUNT_WIDTH-1:0] tx_pkts_snap_r, rx_pkts_snap_r;
  logic [BYTE_WIDTH-1:0]  tx_bytes_snap_r, rx_bytes_snap_r;

  // restoring divider, one quotient bit per cycle
  logic [BYTE_WIDTH-1:0]  quo_r;
  logic [IVAL_W-1:0]      rem_r;
  logic [IVAL_W-1:0]      divisor_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic [IVAL_W:0]        trial;
  logic                   trial_ge;

  ptc_out_t               out_r;

  // packet counting
  logic                   dir;
  logic [COUNT_WIDTH-1:0] sel_pkts, pkts_inc;
  logic [BYTE_WIDTH-1:0]  sel_bytes, bytes_add;
  logic [BYTE_WIDTH:0]    bytes_sum;

  always_comb begin
    if (source_port == monitored_port) begin
      dir = DIR_TX;
    end else if (destination_port == monitored_port) begin
      dir = DIR_RX;
    end else begin
      dir = last_dir_r;
    end
    sel_pkts  = (dir == DIR_RX) ? rx_pkts_r  : tx_pkts_r;
    sel_bytes = (dir == DIR_RX) ? rx_bytes_r : tx_bytes_r;
    pkts_inc  = (sel_pkts == COUNT_MAX) ? COUNT_MAX : sel_pkts + 1'b1;
    bytes_sum = {1'b0, sel_bytes} + (BYTE_WIDTH + 1)'(packet_length);
    bytes_add = bytes_sum[BYTE_WIDTH] ? BYTE_MAX : bytes_sum[BYTE_WIDTH-1:0];
  end

  always_comb begin
    last_dir_nxt = last_dir_r;
    tx_pkts_nxt  = tx_pkts_r;
    tx_bytes_nxt = tx_bytes_r;
    rx_pkts_nxt  = rx_pkts_r;
    rx_bytes_nxt = rx_bytes_r;
    if (cmd.snap) begin
      tx_pkts_nxt  = '0;
      tx_bytes_nxt = '0;
      rx_pkts_nxt  = '0;
      rx_bytes_nxt = '0;
    end else if (cmd.count) begin
      last_dir_nxt = dir;
      if (dir == DIR_RX) begin
        rx_pkts_nxt  = pkts_inc;
        rx_bytes_nxt = bytes_add;
      end else begin
        tx_pkts_nxt  = pkts_inc;
        tx_bytes_nxt = bytes_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dir_r <= DIR_TX;
      tx_pkts_r  <= '0;
      tx_bytes_r <= '0;
      rx_pkts_r  <= '0;
      rx_bytes_r <= '0;
    end else begin
      last_dir_r <= last_dir_nxt;
      tx_pkts_r  <= tx_pkts_nxt;
      tx_bytes_r <= tx_bytes_nxt;
      rx_pkts_r  <= rx_pkts_nxt;
      rx_bytes_r <= rx_bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      time_r          <= tick_time;
      tx_pkts_snap_r  <= tx_pkts_r;
      tx_bytes_snap_r <= tx_bytes_r;
      rx_pkts_snap_r  <= rx_pkts_r;
      rx_bytes_snap_r <= rx_bytes_r;
    end
  end

  assign trial    = {rem_r, quo_r[BYTE_WIDTH-1]};
  assign trial_ge = (trial >= {1'b0, divisor_r});
  assign stat.div_done = (cnt_r == DIV_CNT_W'(BYTE_WIDTH));

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      quo_r     <= tx_bytes_r;
      rem_r     <= '0;
      cnt_r     <= '0;
      divisor_r <= (interval_seconds == '0) ? IVAL_W'(1) : interval_seconds;
    end else if (cmd.div_load_rx) begin
      quo_r <= rx_bytes_snap_r;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[BYTE_WIDTH-2:0], trial_ge};
      rem_r <= trial_ge ? IVAL_W'(trial - {1'b0, divisor_r}) : trial[IVAL_W-1:0];
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.direction    <= cmd.out_rx ? DIR_RX : DIR_TX;
      out_r.report_time  <= time_r;
      out_r.packet_count <= fit_count(cmd.out_rx ? rx_pkts_snap_r : tx_pkts_snap_r);
      out_r.size_eighths <= eighths(cmd.out_rx ? rx_bytes_snap_r : tx_bytes_snap_r);
      out_r.rate_value   <= eighths(quo_r);
      out_r.last         <= cmd.out_rx;
    end
  end

  assign out_item = out_r;

endmodule

>>> hw/rtl/port_direction_traffic_counter.sv
// Packet item: taken one per cycle while idle; no result.
// Tick item: TX result valid once the TX byte snapshot is divided,
//   RX result once TX is taken and RX is divided; input stalls until RX is taken.
// TX and RX share one restoring divider, one quotient bit per cycle.
// Reset (synchronous, rst_n low): counters cleared, direction TX, monitored_port 1521,
//   interval_seconds 30.
module port_direction_traffic_counter
  import ptc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  ptc_in_if.sink               in_ch,
  ptc_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // config registers; user writes them only while no tick is in flight; not enforced
  logic [PORT_W-1:0] mon_port_r;
  logic [IVAL_W-1:0] interval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mon_port_r <= MON_PORT_RST;
      interval_r <= INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MON_PORT: mon_port_r <= cfg_data;
        REG_INTERVAL: interval_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ptc_cmd_t  cmd;
  ptc_stat_t stat;
  ptc_out_t  out_item;

  // controller: sequences tick -> divide TX -> present TX -> divide RX -> present RX
  ptc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.operation),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: classification, saturating counters, snapshot, divider, result register
  ptc_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .monitored_port   (mon_port_r),
    .interval_seconds (interval_r),
    .source_port      (in_ch.source_port),
    .destination_port (in_ch.destination_port),
    .packet_length    (in_ch.packet_length),
    .tick_time        (in_ch.tick_time),
    .out_item         (out_item)
  );

  // result register drives the channel directly
  assign out_ch.direction    = out_item.direction;
  assign out_ch.report_time  = out_item.report_time;
  assign out_ch.packet_count = out_item.packet_count;
  assign out_ch.size_eighths = out_item.size_eighths;
  assign out_ch.rate_value   = out_item.rate_value;
  assign out_ch.last         = out_item.last;

endmodule

>>> tb/ptc_report_checker.sv
// Watches both channels and the register port, predicts every report and
// compares it with what the block sends, in order.
module ptc_report_checker
  import ptc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  ptc_in_if                    in_mon,
  ptc_out_if                   out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   reports_pending
);

  logic [PORT_W-1:0]      mon_port;
  logic [IVAL_W-1:0]      rate_div;
  logic                   cur_dir;
  logic [COUNT_WIDTH-1:0] tx_pkts, rx_pkts;
  logic [BYTE_WIDTH-1:0]  tx_bytes, rx_bytes;
  ptc_out_t               report_q[$];

  // packet counter, holds at full scale
  function automatic logic [COUNT_WIDTH-1:0] bump_count(input logic [COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // byte counter, holds at full scale
  function automatic logic [BYTE_WIDTH-1:0] add_bytes(input logic [BYTE_WIDTH-1:0] b,
                                                       input logic [LEN_W-1:0] len);
    logic [BYTE_WIDTH:0] sum;
    sum = {1'b0, b} + (BYTE_WIDTH + 1)'(len);
    return sum[BYTE_WIDTH] ? {BYTE_WIDTH{1'b1}} : sum[BYTE_WIDTH-1:0];
  endfunction

  function automatic ptc_out_t make_report(input logic dir, input logic [TIME_W-1:0] t,
                                           input logic [COUNT_WIDTH-1:0] pkts,
                                           input logic [BYTE_WIDTH-1:0] bytes);
    ptc_out_t r;
    logic [BYTE_WIDTH-1:0] divisor;
    logic [BYTE_WIDTH-1:0] quot;
    // a zero interval divides by one
    divisor = (rate_div == '0) ? BYTE_WIDTH'(1) : BYTE_WIDTH'(rate_div);
    quot = bytes / divisor;
    r.direction    = dir;
    r.report_time  = t;
    r.packet_count = pkts[PCNT_W-1:0];
    r.size_eighths = SIZE_W'(bytes >> 3);
    r.rate_value   = SIZE_W'(quot >> 3);
    r.last         = (dir == DIR_RX);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    ptc_out_t want;
    if (!rst_n) begin
      mon_port   = MON_PORT_RST;
      rate_div   = INTERVAL_RST;
      cur_dir    = DIR_TX;
      tx_pkts    = '0;
      rx_pkts    = '0;
      tx_bytes   = '0;
      rx_bytes   = '0;
      mismatches = 0;
      report_q.delete();
    end else begin
      // compare first: a report from this edge's input cannot leave yet
      if (out_mon.valid && out_mon.ready) begin
        if (report_q.size() == 0) begin
          mismatches++;
          $display("%0t: report mismatch: expected none, actual dir %0b time %0h count %0h",
                   $time, out_mon.direction, out_mon.report_time, out_mon.packet_count);
        end else begin
          want = report_q.pop_front();
          check_field("direction", 64'(want.direction), 64'(out_mon.direction));
          check_field("report_time", 64'(want.report_time), 64'(out_mon.report_time));
          check_field("packet_count", 64'(want.packet_count), 64'(out_mon.packet_count));
          check_field("size_eighths", 64'(want.size_eighths), 64'(out_mon.size_eighths));
          check_field("rate_value", 64'(want.rate_value), 64'(out_mon.rate_value));
          check_field("last", 64'(want.last), 64'(out_mon.last));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MON_PORT: mon_port = cfg_data;
          REG_INTERVAL: rate_div = cfg_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.operation == OP_PACKET) begin
          // source match wins; no match keeps the last direction
          if (in_mon.source_port == mon_port)
            cur_dir = DIR_TX;
          else if (in_mon.destination_port == mon_port)
            cur_dir = DIR_RX;
          if (cur_dir == DIR_TX) begin
            tx_pkts  = bump_count(tx_pkts);
            tx_bytes = add_bytes(tx_bytes, in_mon.packet_length);
          end else begin
            rx_pkts  = bump_count(rx_pkts);
            rx_bytes = add_bytes(rx_bytes, in_mon.packet_length);
          end
        end else begin
          report_q.push_back(make_report(DIR_TX, in_mon.tick_time, tx_pkts, tx_bytes));
          report_q.push_back(make_report(DIR_RX, in_mon.tick_time, rx_pkts, rx_bytes));
          tx_pkts  = '0;
          rx_pkts  = '0;
          tx_bytes = '0;
          rx_bytes = '0;
        end
      end
    end
    reports_pending = report_q.size();
  end

endmodule

>>> tb/tb_port_direction_traffic_counter.sv
// Stimulus and verdict for the port direction traffic counter.
// Prediction and comparison live in ptc_report_checker.
module tb_port_direction_traffic_counter;
  import ptc_pkg::*;

  localparam int NUM_PHASES     = 6;
  localparam int RAND_PER_PHASE = 88;
  // a tick needs two divides, plus margin
  localparam int DRAIN_CYCLES   = 2 * (BYTE_WIDTH + 1) + 12;
  localparam int SINK_HOLD      = 300;
  localparam int CYCLE_LIMIT    = 400000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int mismatches;
  int reports_pending;
  int cycles = 0;

  // idling controls, shared between the sender and the receiver process
  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  bit hold_sink    = 1'b0;

  logic [PORT_W-1:0] cur_port = MON_PORT_RST;

  ptc_in_if  in_ch ();
  ptc_out_if out_ch ();

  port_direction_traffic_counter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ptc_report_checker report_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .reports_pending (reports_pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog: the slowest legal run is far below this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one item and hold it until taken. Entered and left at a falling edge;
  // valid stays high into the next item unless a gap is drawn.
  task automatic send_item(input logic op, input logic [PORT_W-1:0] sp,
                           input logic [PORT_W-1:0] dp, input logic [LEN_W-1:0] len,
                           input logic [TIME_W-1:0] t);
    int gap;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid            = 1'b1;
    in_ch.operation        = op;
    in_ch.source_port      = sp;
    in_ch.destination_port = dp;
    in_ch.packet_length    = len;
    in_ch.tick_time        = t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random packet, biased so that both port matches and misses are common.
  task automatic send_random_packet();
    logic [PORT_W-1:0] sp;
    logic [PORT_W-1:0] dp;
    logic [LEN_W-1:0]  len;
    int pick;
    sp   = PORT_W'($urandom);
    dp   = PORT_W'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 3)
      sp = cur_port;
    else if (pick < 6)
      dp = cur_port;
    else if (pick == 6) begin
      sp = cur_port;
      dp = cur_port;
    end
    case ($urandom_range(0, 7))
      0: len = '0;
      1: len = '1;
      default: len = LEN_W'($urandom);
    endcase
    // tick_time is don't-care on a packet, randomize it anyway
    send_item(OP_PACKET, sp, dp, len, TIME_W'($urandom));
  endtask

  // Stop offering, wait out every report, then the divider's latency so
  // the block is idle before a register write or the verdict.
  task automatic drain();
    in_ch.valid = 1'b0;
    wait (reports_pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input logic [PORT_W-1:0] port, input logic [IVAL_W-1:0] ival);
    cfg_we    = 1'b1;
    cfg_index = REG_MON_PORT;
    cfg_data  = port;
    @(negedge clk);
    cfg_index = REG_INTERVAL;
    cfg_data  = ival;
    @(negedge clk);
    cfg_we   = 1'b0;
    cur_port = port;
  endtask

  // Receiver: random ready bursts, plus one long hold-off on request.
  initial begin
    int burst;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        out_ch.ready = 1'b0;
        repeat (SINK_HOLD) @(negedge clk);
        hold_sink    = 1'b0;
        out_ch.ready = 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
        out_ch.ready = 1'b0;
        burst = $urandom_range(1, 7);
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Main stimulus
  initial begin
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = REG_MON_PORT;
    cfg_data               = '0;
    in_ch.valid            = 1'b0;
    in_ch.operation        = OP_PACKET;
    in_ch.source_port      = '0;
    in_ch.destination_port = '0;
    in_ch.packet_length    = '0;
    in_ch.tick_time        = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part, reset settings (port 1521, interval 30).
    send_item(OP_PACKET, MON_PORT_RST, 16'd80, 16'd0, 32'd0);             // src match, TX
    send_item(OP_PACKET, 16'd443, MON_PORT_RST, 16'hFFFF, 32'hFFFF_FFFF); // dst match, RX
    send_item(OP_PACKET, 16'd0, 16'd0, 16'd1234, 32'h5A5A_5A5A);          // no match: stays RX
    send_item(OP_PACKET, MON_PORT_RST, MON_PORT_RST, 16'd7, 32'd0);       // both match: src wins
    send_item(OP_PACKET, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0);            // no match: stays TX
    // tick ignores ports and length, even when they match
    send_item(OP_TICK, MON_PORT_RST, MON_PORT_RST, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(OP_TICK, 16'd0, 16'd0, 16'd0, 32'd0);                       // all-zero reports
    send_item(OP_PACKET, 16'd5, MON_PORT_RST, 16'd8, 32'd0);              // RX
    send_item(OP_TICK, 16'hFFFF, 16'd0, 16'hFFFF, 32'h0123_4567);
    send_item(OP_PACKET, 16'd1, 16'd2, 16'd9, 32'd0);                     // tick kept RX
    send_item(OP_PACKET, MON_PORT_RST, 16'd3, 16'hFFFF, 32'd0);
    send_item(OP_PACKET, MON_PORT_RST, 16'd4, 16'hFFFF, 32'd0);
    send_item(OP_PACKET, 16'd6, 16'd7, 16'hFFFF, 32'd0);
    send_item(OP_TICK, 16'd0, 16'hFFFF, 16'd0, 32'h8000_0000);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: set_config(16'd0, 16'd1);
          2: set_config(16'hFFFF, 16'hFFFF);
          3: set_config(PORT_W'($urandom), 16'd0);   // zero interval divides by one
          4: set_config(PORT_W'($urandom), IVAL_W'($urandom_range(2, 65534)));
          default: set_config(MON_PORT_RST, 16'd7);
        endcase
      end
      // last phase runs at full rate on both sides
      if (ph == NUM_PHASES - 1) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        if (ph < NUM_PHASES - 1 && i % 30 == 0) begin
          src_idle_en  = ($urandom_range(0, 2) != 0);
          sink_idle_en = ($urandom_range(0, 2) != 0);
        end
        if (ph == 1 && i == 40) begin
          // receiver stalls while a tick and packets pile up behind it
          hold_sink = 1'b1;
          send_item(OP_TICK, PORT_W'($urandom), PORT_W'($urandom), LEN_W'($urandom),
                    TIME_W'($urandom));
          repeat (8) send_random_packet();
        end
        if (ph == 2 && i == 40)
          drain();   // sender pauses until all reports are out
        if ($urandom_range(0, 99) < 12)
          send_item(OP_TICK, PORT_W'($urandom), PORT_W'($urandom), LEN_W'($urandom),
                    TIME_W'($urandom));
        else
          send_random_packet();
      end
    end

    drain();
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
